@@ sv/rws_pkg.sv @@
// Shared constants, register codes and stage bundle types for the Ricker wavelet unit.
// No dependencies; every design file except rws_checker imports this package.
package rws_pkg;

   // Fixed-point constants
   localparam logic [31:0] PI_Q30         = 32'd3373259426;
   localparam logic [30:0] LOG2E_Q30      = 31'd1549082005;
   localparam logic [29:0] LN2_Q30        = 30'd744261118;
   localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
   localparam logic [23:0] X_FLUSH        = 24'd753664;
   localparam logic [31:0] AMPLITUDE_INIT = 32'h0001_0000;
   localparam logic [37:0] SAT_POS_MAG    = 38'h00_7FFF_FFFF;
   localparam logic [37:0] SAT_NEG_MAG    = 38'h00_8000_0000;

   // Taylor terms of 2^-r
   localparam int TERMS = 12;

   // CSR map
   localparam int          CSR_AW        = 5;
   localparam logic [2:0]  REG_AMPLITUDE = 3'd0;
   localparam logic [2:0]  REG_START     = 3'd1;
   localparam logic [2:0]  REG_FINISH    = 3'd2;
   localparam logic [2:0]  REG_PEAK      = 3'd3;
   localparam logic [2:0]  REG_FREQUENCY = 3'd4;

   typedef struct packed {
      logic signed [31:0] amplitude;
      logic signed [31:0] start_time;
      logic signed [31:0] finish_time;
      logic signed [31:0] peak_delay;
      logic [31:0]        frequency;
   } rws_cfg_type;

   typedef struct packed {
      logic        valid;
      logic        in_window;
      logic        flush;
      logic [19:0] x16;
   } rws_front_type;

   typedef struct packed {
      logic        valid;
      logic        in_window;
      logic        flush;
      logic [19:0] x16;
      logic [30:0] e30;
   } rws_exp_type;

   typedef struct packed {
      logic               valid;
      logic               in_window;
      logic signed [31:0] wavelet_value;
   } rws_back_type;

endpackage

@@ sv/rws_csr.sv @@
// Configuration registers behind an APB-style port.
// Depends on rws_pkg for the register map and the rws_cfg_type bundle.
module rws_csr
   import rws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output rws_cfg_type       cfg
);

   rws_cfg_type cfg_ff;
   rws_cfg_type cfg_in;
   logic        wr_en;
   logic [2:0]  reg_sel;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[CSR_AW-1:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_AMPLITUDE: cfg_in.amplitude   = csr_pwdata;
            REG_START:     cfg_in.start_time  = csr_pwdata;
            REG_FINISH:    cfg_in.finish_time = csr_pwdata;
            REG_PEAK:      cfg_in.peak_delay  = csr_pwdata;
            REG_FREQUENCY: cfg_in.frequency   = csr_pwdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_AMPLITUDE: csr_prdata = cfg_ff.amplitude;
         REG_START:     csr_prdata = cfg_ff.start_time;
         REG_FINISH:    csr_prdata = cfg_ff.finish_time;
         REG_PEAK:      csr_prdata = cfg_ff.peak_delay;
         REG_FREQUENCY: csr_prdata = cfg_ff.frequency;
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.amplitude   <= AMPLITUDE_INIT;
         cfg_ff.start_time  <= '0;
         cfg_ff.finish_time <= '0;
         cfg_ff.peak_delay  <= '0;
         cfg_ff.frequency   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/rws_front.sv @@
// Front pipeline: window test, tau, frequency*|tau|, pi scaling and squaring to x in Q4.16.
// Depends on rws_pkg; six register stages, all held when adv is low.
module rws_front
   import rws_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               req_valid,
   input  logic signed [31:0] req_sample_time,
   input  rws_cfg_type        cfg,
   output rws_front_type      front_out
);

   // stage 1: capture the sample
   logic               s1_valid_ff;
   logic signed [31:0] s1_time_ff;

   // stage 2: window test and t - start
   logic               s2_valid_ff;
   logic               s2_win_ff;
   logic               s2_win_in;
   logic signed [32:0] s2_diff_ff;
   logic signed [32:0] s2_diff_in;

   // stage 3: |tau|
   logic               s3_valid_ff;
   logic               s3_win_ff;
   logic signed [33:0] s3_tau;
   logic signed [33:0] s3_tau_neg;
   logic [32:0]        s3_atau_ff;
   logic [32:0]        s3_atau_in;

   // stage 4: P = frequency * |tau|
   logic               s4_valid_ff;
   logic               s4_win_ff;
   logic [64:0]        s4_prod;
   logic               s4_big_ff;
   logic               s4_big_in;
   logic [33:0]        s4_p_ff;

   // stage 5: y = pi * P
   logic               s5_valid_ff;
   logic               s5_win_ff;
   logic               s5_big_ff;
   logic [61:0]        s5_prod;
   logic [31:0]        s5_y_ff;

   // stage 6: x = y^2
   logic [63:0]        s6_sq;
   logic [23:0]        s6_x;
   rws_front_type      front_ff;
   rws_front_type      front_in;

   assign s2_win_in  = (s1_time_ff >= cfg.start_time) && (s1_time_ff <= cfg.finish_time);
   assign s2_diff_in = $signed({s1_time_ff[31], s1_time_ff})
                     - $signed({cfg.start_time[31], cfg.start_time});

   assign s3_tau     = $signed({s2_diff_ff[32], s2_diff_ff})
                     - $signed({{2{cfg.peak_delay[31]}}, cfg.peak_delay});
   assign s3_tau_neg = -s3_tau;
   assign s3_atau_in = s3_tau[33] ? s3_tau_neg[32:0] : s3_tau[32:0];

   assign s4_prod    = 65'(cfg.frequency) * 65'(s3_atau_ff);
   // flush when P reaches 4.0 (2^34 in Q32.32)
   assign s4_big_in  = |s4_prod[64:34];

   assign s5_prod    = 62'(s4_p_ff[33:4]) * 62'(PI_Q30);

   assign s6_sq      = 64'(s5_y_ff) * 64'(s5_y_ff);
   assign s6_x       = s6_sq[63:40];

   always_comb begin
      front_in.valid     = s5_valid_ff;
      front_in.in_window = s5_win_ff;
      front_in.flush     = s5_big_ff || (s6_x > X_FLUSH);
      front_in.x16       = s6_x[19:0];
   end

   assign front_out = front_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         s5_valid_ff    <= 1'b0;
         front_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s1_time_ff  <= req_sample_time;

         s2_valid_ff <= s1_valid_ff;
         s2_win_ff   <= s2_win_in;
         s2_diff_ff  <= s2_diff_in;

         s3_valid_ff <= s2_valid_ff;
         s3_win_ff   <= s2_win_ff;
         s3_atau_ff  <= s3_atau_in;

         s4_valid_ff <= s3_valid_ff;
         s4_win_ff   <= s3_win_ff;
         s4_big_ff   <= s4_big_in;
         s4_p_ff     <= s4_prod[33:0];

         s5_valid_ff <= s4_valid_ff;
         s5_win_ff   <= s4_win_ff;
         s5_big_ff   <= s4_big_ff;
         s5_y_ff     <= s5_prod[61:30];

         front_ff    <= front_in;
      end
   end

endmodule

@@ sv/rws_exp.sv @@
// Exponential pipeline: exp(-x) by base-2 range reduction and a 12-term Taylor series.
// Depends on rws_pkg; each term takes three stages (product, reciprocal divide, fix-up).
module rws_exp
   import rws_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  rws_front_type front_in,
   output rws_exp_type   exp_out
);

   typedef struct packed {
      logic        in_window;
      logic        flush;
      logic [19:0] x16;
      logic [4:0]  n;
      logic [29:0] u;
   } rws_side_type;

   // stage E1: z = x*log2(e), split into n and r
   logic [50:0]  e1_zprod;
   logic [34:0]  e1_z30;
   logic         e1_valid_ff;
   rws_side_type e1_side_ff;
   rws_side_type e1_side_in;
   logic [29:0]  e1_r_ff;

   // stage E2: u = r*ln2
   logic [59:0]  e2_uprod;
   logic         e2_valid_ff;
   rws_side_type e2_side_ff;
   rws_side_type e2_side_in;

   // Taylor stages
   logic               a_valid_ff [TERMS];
   rws_side_type       a_side_ff  [TERMS];
   logic [29:0]        a_m_ff     [TERMS];
   logic signed [31:0] a_sum_ff   [TERMS];
   logic               b_valid_ff [TERMS];
   rws_side_type       b_side_ff  [TERMS];
   logic [29:0]        b_m_ff     [TERMS];
   logic [29:0]        b_q0_ff    [TERMS];
   logic signed [31:0] b_sum_ff   [TERMS];
   logic               c_valid_ff [TERMS];
   rws_side_type       c_side_ff  [TERMS];
   logic [29:0]        c_term_ff  [TERMS];
   logic signed [31:0] c_sum_ff   [TERMS];

   // final stage: clamp and shift by n
   logic signed [31:0] fin_sum;
   rws_exp_type        exp_ff;
   rws_exp_type        exp_in;

   assign e1_zprod = 51'(front_in.x16) * 51'(LOG2E_Q30);
   assign e1_z30   = e1_zprod[50:16];

   always_comb begin
      e1_side_in.in_window = front_in.in_window;
      e1_side_in.flush     = front_in.flush;
      e1_side_in.x16       = front_in.x16;
      e1_side_in.n         = e1_z30[34:30];
      e1_side_in.u         = '0;
   end

   assign e2_uprod = 60'(e1_r_ff) * 60'(LN2_Q30);

   always_comb begin
      e2_side_in   = e1_side_ff;
      e2_side_in.u = e2_uprod[59:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff <= front_in.valid;
         e1_side_ff  <= e1_side_in;
         e1_r_ff     <= e1_z30[29:0];
         e2_valid_ff <= e1_valid_ff;
         e2_side_ff  <= e2_side_in;
      end
   end

   for (genvar k = 0; k < TERMS; k++) begin : g_term
      localparam int unsigned K        = k + 1;
      localparam logic [32:0] RECIP    = 33'((64'd1 << 32) / K);
      localparam bit          SUBTRACT = (K % 2) == 1;

      logic [30:0]        term_src;
      logic signed [31:0] sum_src;
      rws_side_type       side_src;
      logic               valid_src;
      logic [60:0]        a_prod;
      logic [29:0]        a_m_in;
      logic [62:0]        b_prod;
      logic [29:0]        b_q0_in;
      logic [33:0]        c_qk;
      logic [33:0]        c_rem;
      logic               c_fix;
      logic [29:0]        c_term_in;
      logic signed [31:0] c_sum_in;

      if (k == 0) begin : g_first
         assign term_src  = ONE_Q30;
         assign sum_src   = $signed({1'b0, ONE_Q30});
         assign side_src  = e2_side_ff;
         assign valid_src = e2_valid_ff;
      end else begin : g_next
         assign term_src  = {1'b0, c_term_ff[k-1]};
         assign sum_src   = c_sum_ff[k-1];
         assign side_src  = c_side_ff[k-1];
         assign valid_src = c_valid_ff[k-1];
      end

      assign a_prod  = 61'(term_src) * 61'(side_src.u);
      assign a_m_in  = a_prod[59:30];

      // quotient estimate is exact or one low
      assign b_prod  = 63'(a_m_ff[k]) * 63'(RECIP);
      assign b_q0_in = b_prod[61:32];

      assign c_qk      = 34'(b_q0_ff[k]) * 34'(K);
      assign c_rem     = 34'(b_m_ff[k]) - c_qk;
      assign c_fix     = c_rem >= 34'(K);
      assign c_term_in = b_q0_ff[k] + 30'(c_fix);
      assign c_sum_in  = SUBTRACT ? b_sum_ff[k] - $signed({2'b00, c_term_in})
                                  : b_sum_ff[k] + $signed({2'b00, c_term_in});

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[k] <= 1'b0;
            b_valid_ff[k] <= 1'b0;
            c_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            a_valid_ff[k] <= valid_src;
            a_side_ff[k]  <= side_src;
            a_m_ff[k]     <= a_m_in;
            a_sum_ff[k]   <= sum_src;

            b_valid_ff[k] <= a_valid_ff[k];
            b_side_ff[k]  <= a_side_ff[k];
            b_m_ff[k]     <= a_m_ff[k];
            b_q0_ff[k]    <= b_q0_in;
            b_sum_ff[k]   <= a_sum_ff[k];

            c_valid_ff[k] <= b_valid_ff[k];
            c_side_ff[k]  <= b_side_ff[k];
            c_term_ff[k]  <= c_term_in;
            c_sum_ff[k]   <= c_sum_in;
         end
      end
   end

   assign fin_sum = c_sum_ff[TERMS-1];

   always_comb begin
      exp_in.valid     = c_valid_ff[TERMS-1];
      exp_in.in_window = c_side_ff[TERMS-1].in_window;
      exp_in.flush     = c_side_ff[TERMS-1].flush;
      exp_in.x16       = c_side_ff[TERMS-1].x16;
      // drop a negative sum to zero
      exp_in.e30       = fin_sum[31] ? '0 : (fin_sum[30:0] >> c_side_ff[TERMS-1].n);
   end

   assign exp_out = exp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff.valid <= 1'b0;
      end else if (adv) begin
         exp_ff <= exp_in;
      end
   end

endmodule

@@ sv/rws_back.sv @@
// Back pipeline: amplitude*(2x-1)*exp(-x), magnitude truncation, sign and saturation.
// Depends on rws_pkg; four register stages, all held when adv is low.
module rws_back
   import rws_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  rws_exp_type        exp_in,
   input  logic signed [31:0] amplitude,
   output rws_back_type       back_out
);

   // stage B1: |amplitude| * |2x - 1|
   logic signed [21:0] b1_w;
   logic signed [21:0] b1_w_neg;
   logic [20:0]        b1_w_abs;
   logic [31:0]        b1_amp_abs;
   logic [52:0]        b1_prod;
   logic               b1_valid_ff;
   logic               b1_keep_ff;
   logic               b1_win_ff;
   logic               b1_neg_ff;
   logic [51:0]        b1_ap_ff;
   logic [30:0]        b1_e30_ff;

   // stage B2: high partial product
   logic [52:0]        b2_hi_in;
   logic               b2_valid_ff;
   logic               b2_keep_ff;
   logic               b2_win_ff;
   logic               b2_neg_ff;
   logic [52:0]        b2_hi_ff;
   logic [29:0]        b2_lo_ff;
   logic [30:0]        b2_e30_ff;

   // stage B3: low partial product
   logic [60:0]        b3_prod;
   logic               b3_valid_ff;
   logic               b3_keep_ff;
   logic               b3_win_ff;
   logic               b3_neg_ff;
   logic [52:0]        b3_hi_ff;
   logic [30:0]        b3_lo_ff;

   // stage B4: sum, sign, saturate
   logic [53:0]        b4_total;
   logic [37:0]        b4_mag;
   logic [37:0]        b4_mag_neg;
   rws_back_type       back_ff;
   rws_back_type       back_in;

   assign b1_w       = $signed({1'b0, exp_in.x16, 1'b0}) - 22'sd65536;
   assign b1_w_neg   = -b1_w;
   assign b1_w_abs   = b1_w[21] ? b1_w_neg[20:0] : b1_w[20:0];
   assign b1_amp_abs = amplitude[31] ? (~amplitude + 32'd1) : amplitude;
   assign b1_prod    = 53'(b1_amp_abs) * 53'(b1_w_abs);

   assign b2_hi_in   = 53'(b1_ap_ff[51:30]) * 53'(b1_e30_ff);

   assign b3_prod    = 61'(b2_lo_ff) * 61'(b2_e30_ff);

   assign b4_total   = 54'(b3_hi_ff) + 54'(b3_lo_ff);
   assign b4_mag     = b4_total[53:16];
   assign b4_mag_neg = -b4_mag;

   always_comb begin
      back_in.valid     = b3_valid_ff;
      back_in.in_window = b3_win_ff;
      if (!b3_keep_ff) begin
         back_in.wavelet_value = '0;
      end else if (b3_neg_ff) begin
         back_in.wavelet_value = (b4_mag > SAT_NEG_MAG) ? SAT_NEG_MAG[31:0] : b4_mag_neg[31:0];
      end else begin
         back_in.wavelet_value = (b4_mag > SAT_POS_MAG) ? SAT_POS_MAG[31:0] : b4_mag[31:0];
      end
   end

   assign back_out = back_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff   <= 1'b0;
         b2_valid_ff   <= 1'b0;
         b3_valid_ff   <= 1'b0;
         back_ff.valid <= 1'b0;
      end else if (adv) begin
         b1_valid_ff <= exp_in.valid;
         b1_keep_ff  <= exp_in.in_window & ~exp_in.flush;
         b1_win_ff   <= exp_in.in_window;
         b1_neg_ff   <= amplitude[31] ^ b1_w[21];
         b1_ap_ff    <= b1_prod[51:0];
         b1_e30_ff   <= exp_in.e30;

         b2_valid_ff <= b1_valid_ff;
         b2_keep_ff  <= b1_keep_ff;
         b2_win_ff   <= b1_win_ff;
         b2_neg_ff   <= b1_neg_ff;
         b2_hi_ff    <= b2_hi_in;
         b2_lo_ff    <= b1_ap_ff[29:0];
         b2_e30_ff   <= b1_e30_ff;

         b3_valid_ff <= b2_valid_ff;
         b3_keep_ff  <= b2_keep_ff;
         b3_win_ff   <= b2_win_ff;
         b3_neg_ff   <= b2_neg_ff;
         b3_hi_ff    <= b2_hi_ff;
         b3_lo_ff    <= b3_prod[60:30];

         back_ff     <= back_in;
      end
   end

endmodule

@@ sv/ricker_wavelet_sample_unit.sv @@
// Ricker wavelet sample unit: one Q16.16 sample time in, one saturated wavelet value out.
//
// Usage:
//   req_ channel carries sample_time; a beat is taken when req_valid is high and
//   req_stall is low. rsp_ channel returns wavelet_value and in_window for every
//   request beat, in order; a beat leaves when rsp_valid is high and rsp_stall low.
//   csr_ is an APB-style port: amplitude at 0x00, start_time 0x04, finish_time 0x08,
//   peak_delay 0x0C, frequency 0x10. Write it only while no request is in flight.
// Timing:
//   One beat per cycle sustained while rsp_stall stays low. A result reaches rsp_ from
//   its request beat through 6 front stages, 2 range-reduction stages, 36 Taylor stages
//   (three per term), 1 shift stage, 4 product stages and the output register.
// Reset (synchronous): pipeline and output empty, amplitude 1.0, other registers zero.
// Backpressure: while rsp_stall holds a result, one more finished result parks in a
//   skid register; then req_stall rises and every stage holds until rsp_ drains.
// Depends on rws_pkg, rws_csr, rws_front, rws_exp and rws_back.
module ricker_wavelet_sample_unit
   import rws_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_wavelet_value,
   output logic               rsp_in_window,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   rws_cfg_type   cfg;
   rws_front_type front_bus;
   rws_exp_type   exp_bus;
   rws_back_type  back_bus;
   logic          adv;
   logic          pop;
   logic          push;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [31:0] rsp_value_ff;
   logic signed [31:0] rsp_value_in;
   logic               rsp_win_ff;
   logic               rsp_win_in;
   logic               skid_full_ff;
   logic               skid_full_in;
   logic signed [31:0] skid_value_ff;
   logic signed [31:0] skid_value_in;
   logic               skid_win_ff;
   logic               skid_win_in;

   rws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rws_front u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .req_valid       (req_valid),
      .req_sample_time (req_sample_time),
      .cfg             (cfg),
      .front_out       (front_bus)
   );

   rws_exp u_exp (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .front_in (front_bus),
      .exp_out  (exp_bus)
   );

   rws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .exp_in    (exp_bus),
      .amplitude (cfg.amplitude),
      .back_out  (back_bus)
   );

   // the pipeline moves as long as the skid register is free
   assign adv       = ~skid_full_ff;
   assign req_stall = skid_full_ff;
   assign pop       = rsp_valid_ff & ~rsp_stall;
   assign push      = adv & back_bus.valid;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_win_in    = rsp_win_ff;
      skid_full_in  = skid_full_ff;
      skid_value_in = skid_value_ff;
      skid_win_in   = skid_win_ff;
      if (skid_full_ff) begin
         if (pop) begin
            // advance the parked beat
            rsp_value_in = skid_value_ff;
            rsp_win_in   = skid_win_ff;
            skid_full_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = back_bus.wavelet_value;
            rsp_win_in   = back_bus.in_window;
         end else begin
            skid_full_in  = 1'b1;
            skid_value_in = back_bus.wavelet_value;
            skid_win_in   = back_bus.in_window;
         end
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_win_ff    <= rsp_win_in;
      skid_value_ff <= skid_value_in;
      skid_win_ff   <= skid_win_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wavelet_value = rsp_value_ff;
   assign rsp_in_window     = rsp_win_ff;

endmodule

@@ sv/rws_checker.sv @@
// Port-level assertions for the Ricker wavelet unit, bound to the top level.
// Depends on the ports of ricker_wavelet_sample_unit only.
module rws_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_wavelet_value,
   input logic               rsp_in_window
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_wavelet_value)
                                 && $stable(rsp_in_window))
      else $error("rsp beat changed while stalled");

   // outside the window the value is forced to zero
   a_zero_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_window |-> rsp_wavelet_value == 32'sd0)
      else $error("nonzero value outside window");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // input backpressure only follows a held output beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without output backpressure");

endmodule

bind ricker_wavelet_sample_unit rws_checker u_rws_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_wavelet_value (rsp_wavelet_value),
   .rsp_in_window     (rsp_in_window)
);
